// ===== hdl/sle_pkg.sv =====
// shared constants and types for the sequential list engine
package sle_pkg;

  localparam int CAPACITY = 128;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CMP_W    = ((CNT_W > 8) ? CNT_W : 8) + 1;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_DELETE = 3'd1,
    OP_GET    = 3'd2,
    OP_LOCATE = 3'd3,
    OP_PRIOR  = 3'd4,
    OP_NEXT   = 3'd5,
    OP_CLEAR  = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BADPOS   = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_NONEIGH  = 2'd3
  } st_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DONE
  } sle_state_t;

endpackage

// ===== hdl/sequential_list_engine.sv =====
// ordered list of signed 32-bit words in a single-port-read memory with a length counter
//
// One input word is taken at a time; the block stalls its input until the result is
// placed in the output register. The list lives in a CAPACITY x 32 memory with one
// write and one registered read per cycle, and every walk moves one entry per cycle.
// Rejected items, clear, and locate, prior or next on an empty list skip the walk;
// get reads one entry; insert and delete walk from the position to the end of the
// list; locate and prior stop at the first match, next also reads the entry after
// it, and an absent key walks the whole list. While a result waits and the output
// is stalled, the block holds in its done state. The output register lets the next
// item start while a result still waits to be taken.
// No clearing pass runs after reset: the length counter alone marks which entries
// hold data.
module sequential_list_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_opcode,
  input  logic [7:0]         in_position,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_data_out,
  output logic [7:0]         out_found_position,
  output logic [7:0]         out_length,
  output logic               out_is_empty
);
  import sle_pkg::*;

  sle_state_t       state_r, state_nxt;
  op_t              op_r, op_nxt;
  logic [31:0]      key_r, key_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] first_r, first_nxt;
  logic [CNT_W-1:0] last_r, last_nxt;
  logic [CNT_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic             rd_go_r, rd_go_nxt;
  logic             rd_v_r, rd_v_nxt;
  logic [CNT_W-1:0] s_idx_r, s_idx_nxt;
  logic [31:0]      carry_r, carry_nxt;
  logic [31:0]      prev_r, prev_nxt;
  logic             grab_r, grab_nxt;
  st_t              res_st_r, res_st_nxt;
  logic [31:0]      res_data_r, res_data_nxt;
  logic [CNT_W-1:0] res_fpos_r, res_fpos_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       out_status_r;
  logic [31:0]      out_data_r;
  logic [7:0]       out_fpos_r;
  logic [7:0]       out_len_r;
  logic             out_empty_r;

  logic [31:0]      mem [CAPACITY];
  logic [31:0]      mem_q_r;
  logic             mem_we;
  logic [IDX_W-1:0] mem_wa;
  logic [31:0]      mem_wd;
  logic             rd_en;

  logic             accept;
  logic             start_run;
  logic             fin;
  logic             out_free;
  logic [CMP_W-1:0] pos_c;
  logic [CMP_W-1:0] cnt_c;
  logic [CNT_W-1:0] pos_m1;
  logic [CNT_W-1:0] cnt_m1;
  logic [CNT_W-1:0] s_dec;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign pos_c    = CMP_W'(in_position);
  assign cnt_c    = CMP_W'(cnt_r);
  assign pos_m1   = CNT_W'(pos_c - CMP_W'(1));
  assign cnt_m1   = cnt_r - CNT_W'(1);
  assign s_dec    = s_idx_r - CNT_W'(1);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = start_run ? S_RUN : S_DONE;
        end
      end
      S_RUN: begin
        if (fin) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    op_nxt       = op_r;
    key_nxt      = key_r;
    cnt_nxt      = cnt_r;
    first_nxt    = first_r;
    last_nxt     = last_r;
    rd_ptr_nxt   = rd_ptr_r;
    rd_go_nxt    = rd_go_r;
    rd_v_nxt     = rd_v_r;
    s_idx_nxt    = s_idx_r;
    carry_nxt    = carry_r;
    prev_nxt     = prev_r;
    grab_nxt     = grab_r;
    res_st_nxt   = res_st_r;
    res_data_nxt = res_data_r;
    res_fpos_nxt = res_fpos_r;
    mem_we       = 1'b0;
    mem_wa       = s_idx_r[IDX_W-1:0];
    mem_wd       = carry_r;
    rd_en        = 1'b0;
    start_run    = 1'b0;
    fin          = 1'b0;

    if (state_r == S_IDLE && accept) begin
      op_nxt       = op_t'(in_opcode);
      key_nxt      = in_value;
      res_st_nxt   = ST_OK;
      res_data_nxt = '0;
      res_fpos_nxt = '0;
      grab_nxt     = 1'b0;
      rd_v_nxt     = 1'b0;
      rd_go_nxt    = 1'b0;
      carry_nxt    = in_value;
      unique case (op_t'(in_opcode))
        OP_INSERT: begin
          if (pos_c == '0 || pos_c > cnt_c + CMP_W'(1) || cnt_c >= CMP_W'(CAPACITY)) begin
            res_st_nxt = ST_BADPOS;
          end else begin
            rd_ptr_nxt = pos_m1;
            last_nxt   = cnt_r;
            rd_go_nxt  = 1'b1;
            start_run  = 1'b1;
          end
        end
        OP_DELETE, OP_GET: begin
          if (pos_c == '0 || pos_c > cnt_c) begin
            res_st_nxt = ST_BADPOS;
          end else begin
            rd_ptr_nxt = pos_m1;
            first_nxt  = pos_m1;
            last_nxt   = (op_t'(in_opcode) == OP_DELETE) ? cnt_m1 : pos_m1;
            rd_go_nxt  = 1'b1;
            start_run  = 1'b1;
          end
        end
        OP_LOCATE, OP_PRIOR, OP_NEXT: begin
          if (cnt_r == '0) begin
            res_st_nxt = ST_NOTFOUND;
          end else begin
            rd_ptr_nxt = '0;
            last_nxt   = cnt_m1;
            rd_go_nxt  = 1'b1;
            start_run  = 1'b1;
          end
        end
        OP_CLEAR: begin
          cnt_nxt = '0;
        end
        default: begin
          res_st_nxt = ST_BADPOS;
        end
      endcase
    end else if (state_r == S_RUN) begin
      // read issue
      if (rd_go_r) begin
        rd_en     = 1'b1;
        rd_v_nxt  = 1'b1;
        s_idx_nxt = rd_ptr_r;
        if (rd_ptr_r == last_r) begin
          rd_go_nxt = 1'b0;
        end else begin
          rd_ptr_nxt = rd_ptr_r + CNT_W'(1);
        end
      end else begin
        rd_v_nxt = 1'b0;
      end
      // read data returns
      if (rd_v_r) begin
        unique case (op_r)
          OP_INSERT: begin
            mem_we    = 1'b1;
            mem_wa    = s_idx_r[IDX_W-1:0];
            mem_wd    = carry_r;
            carry_nxt = mem_q_r;
            if (s_idx_r == last_r) begin
              cnt_nxt = cnt_r + CNT_W'(1);
              fin     = 1'b1;
            end
          end
          OP_DELETE: begin
            if (s_idx_r == first_r) begin
              res_data_nxt = mem_q_r;
            end else begin
              mem_we = 1'b1;
              mem_wa = s_dec[IDX_W-1:0];
              mem_wd = mem_q_r;
            end
            if (s_idx_r == last_r) begin
              cnt_nxt = cnt_m1;
              fin     = 1'b1;
            end
          end
          OP_GET: begin
            res_data_nxt = mem_q_r;
            fin          = 1'b1;
          end
          OP_LOCATE, OP_PRIOR, OP_NEXT: begin
            if (grab_r) begin
              res_data_nxt = mem_q_r;
              fin          = 1'b1;
            end else if (mem_q_r == key_r) begin
              if (op_r == OP_LOCATE) begin
                res_fpos_nxt = s_idx_r + CNT_W'(1);
                fin          = 1'b1;
              end else if (op_r == OP_PRIOR) begin
                if (s_idx_r == '0) begin
                  res_st_nxt = ST_NONEIGH;
                end else begin
                  res_data_nxt = prev_r;
                end
                fin = 1'b1;
              end else begin
                if (s_idx_r == last_r) begin
                  res_st_nxt = ST_NONEIGH;
                  fin        = 1'b1;
                end else begin
                  grab_nxt  = 1'b1;
                  rd_go_nxt = 1'b0;
                end
              end
            end else begin
              prev_nxt = mem_q_r;
              if (s_idx_r == last_r) begin
                res_st_nxt = ST_NOTFOUND;
                fin        = 1'b1;
              end
            end
          end
          default: begin
            fin = 1'b1;
          end
        endcase
        if (fin) begin
          rd_go_nxt = 1'b0;
          rd_v_nxt  = 1'b0;
        end
      end
    end
  end

  // output register control
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (state_r == S_DONE && out_free) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      mem_q_r <= mem[rd_ptr_r[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      rd_go_r     <= 1'b0;
      rd_v_r      <= 1'b0;
      grab_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rd_go_r     <= rd_go_nxt;
      rd_v_r      <= rd_v_nxt;
      grab_r      <= grab_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    key_r      <= key_nxt;
    first_r    <= first_nxt;
    last_r     <= last_nxt;
    rd_ptr_r   <= rd_ptr_nxt;
    s_idx_r    <= s_idx_nxt;
    carry_r    <= carry_nxt;
    prev_r     <= prev_nxt;
    res_st_r   <= res_st_nxt;
    res_data_r <= res_data_nxt;
    res_fpos_r <= res_fpos_nxt;
    if (state_r == S_DONE && out_free) begin
      out_status_r <= res_st_r;
      out_data_r   <= (res_st_r == ST_OK) ? res_data_r : '0;
      out_fpos_r   <= 8'(res_fpos_r);
      out_len_r    <= 8'(cnt_r);
      out_empty_r  <= (cnt_r == '0);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_data_out       = out_data_r;
  assign out_found_position = out_fpos_r;
  assign out_length         = out_len_r;
  assign out_is_empty       = out_empty_r;

endmodule
